// ----- src/cbht_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cbht_pkg;
    localparam int MAX_BOXES_DEF   = 16;
    localparam int MAX_BUTTONS_DEF = 32;
    localparam int COORD_BITS_DEF  = 16;
    localparam int ID_W  = 4;
    localparam int BTN_W = 5;
    localparam int RW    = 15;

    localparam logic [2:0] ACT_ADD_FRONT = 3'd0;
    localparam logic [2:0] ACT_ADD_BACK  = 3'd1;
    localparam logic [2:0] ACT_REMOVE    = 3'd2;
    localparam logic [2:0] ACT_APPEND    = 3'd3;
    localparam logic [2:0] ACT_CHECK     = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BOX_FULL = 2'd1;
    localparam logic [1:0] ST_BTN_FULL = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE, OP_LATCH, OP_CHK_FULL, OP_ADD, OP_SHIFT, OP_REM, OP_APPEND,
        OP_HT_START, OP_BOX_RD, OP_BOX_TST, OP_BTN_RD, OP_BTN_TST,
        OP_HT_END, OP_FINISH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] phase;
    } cmd_t;

    typedef struct packed {
        logic is_add;
        logic is_rem;
        logic is_app;
        logic is_chk;
        logic full;
        logic shift_done;
        logic rem_done;
        logic box_end;
        logic box_in;
        logic btn_end;
        logic btn_in;
        logic ph_down;
        logic ph_up;
    } stat_t;
endpackage
`default_nettype wire

// ----- src/cbht_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbht_datapath
    import cbht_pkg::*;
#(
    parameter int MAX_BOXES   = MAX_BOXES_DEF,
    parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [2:0]            in_action,
    input  wire logic [ID_W-1:0]       in_box,
    input  wire logic [6*COORD_BITS-1:0] in_pos,
    input  wire logic [RW-1:0]         in_w,
    input  wire logic [RW-1:0]         in_h,
    input  wire logic [2:0]            in_flags,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    output logic [15:0]                result
);
    localparam int BI  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int LW  = $clog2(MAX_BOXES + 1);
    localparam int NI  = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
    localparam int NW  = $clog2(MAX_BUTTONS + 1);
    localparam int CB  = COORD_BITS;
    localparam int DW  = ((CB > RW) ? CB : RW) + 2;
    localparam int RCW = 2 * CB + 2 * RW;

    logic [RCW-1:0] box_mem [MAX_BOXES];
    logic [RCW-1:0] btn_mem [MAX_BOXES*(2**NI)];
    logic [BI-1:0]  order_reg [MAX_BOXES];
    logic [NW-1:0]  cnt_reg [MAX_BOXES];
    logic [LW-1:0]  len_reg;

    logic [2:0]      act_reg;
    logic [ID_W-1:0] box_reg;
    logic [CB-1:0]   px_reg [3];
    logic [CB-1:0]   py_reg [3];
    logic [RW-1:0]   w_reg, h_reg;
    logic [2:0]      flg_reg;
    logic [1:0]      status_reg;

    logic [LW-1:0]   i_reg, k_reg;
    logic [NW-1:0]   j_reg, n_reg;
    logic [BI-1:0]   cur_reg;
    logic [RCW-1:0]  rd_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic signed [CB-1:0] tx_reg, ty_reg;

    logic sbv_reg, sbt_reg;
    logic [BI-1:0] sb_reg;
    logic [NI-1:0] st_reg;
    logic tbv_reg, ttv_reg;
    logic [BI-1:0] tb_reg;
    logic [NI-1:0] tt_reg;
    logic held_reg, pr_reg, rel_reg;

    logic valid_id;
    assign valid_id = ({{(32-ID_W){1'b0}}, box_reg} < 32'(MAX_BOXES));
    logic [BI-1:0] bidx;
    assign bidx = BI'(box_reg);

    logic signed [DW-1:0] rx, ry, rw_s, rh_s, ddx, ddy;
    assign rx   = DW'($signed(rd_reg[CB-1:0]));
    assign ry   = DW'($signed(rd_reg[2*CB-1:CB]));
    assign rw_s = $signed({{(DW-RW){1'b0}}, rd_reg[2*CB+RW-1:2*CB]});
    assign rh_s = $signed({{(DW-RW){1'b0}}, rd_reg[RCW-1:2*CB+RW]});
    assign ddx  = dx_reg - rx;
    assign ddy  = dy_reg - ry;

    logic box_in, btn_in;
    logic signed [DW-1:0] bx, by;
    assign bx = DW'(tx_reg) - rx;
    assign by = DW'(ty_reg) - ry;
    assign box_in = (bx >= 0) && (bx < rw_s) && (by >= 0) && (by < rh_s);
    assign btn_in = (ddx >= 0) && (ddx < rw_s) && (ddy >= 0) && (ddy < rh_s);

    always_comb
    begin
        stat.is_add     = valid_id && (act_reg == ACT_ADD_FRONT || act_reg == ACT_ADD_BACK);
        stat.is_rem     = valid_id && act_reg == ACT_REMOVE;
        stat.is_app     = valid_id && act_reg == ACT_APPEND;
        stat.is_chk     = act_reg == ACT_CHECK;
        stat.full       = stat.is_add ? (len_reg >= LW'(MAX_BOXES))
                                      : (cnt_reg[bidx] >= NW'(MAX_BUTTONS));
        stat.shift_done = (act_reg != ACT_ADD_FRONT) || (i_reg == '0);
        stat.rem_done   = i_reg >= len_reg;
        stat.box_end    = i_reg >= len_reg;
        stat.box_in     = box_in;
        stat.btn_end    = j_reg >= n_reg;
        stat.btn_in     = btn_in;
        stat.ph_down    = flg_reg[1];
        stat.ph_up      = flg_reg[2];
    end

    logic [RCW-1:0] wr_rect;
    assign wr_rect = {h_reg, w_reg, py_reg[0], px_reg[0]};

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ADD:    box_mem[bidx] <= wr_rect;
            OP_APPEND: btn_mem[{bidx, NI'(cnt_reg[bidx])}] <= wr_rect;
            default: ;
        endcase
        if (cmd.op == OP_BOX_RD)
            rd_reg <= box_mem[order_reg[BI'(i_reg)]];
        else if (cmd.op == OP_BTN_RD)
            rd_reg <= btn_mem[{cur_reg, NI'(j_reg)}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            for (int b = 0; b < MAX_BOXES; b++)
                cnt_reg[b] <= '0;
            tbv_reg <= 1'b0; ttv_reg <= 1'b0;
            tb_reg <= '0; tt_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_LATCH:
                begin
                    act_reg <= in_action; box_reg <= in_box;
                    px_reg[0] <= in_pos[CB-1:0];     py_reg[0] <= in_pos[2*CB-1:CB];
                    px_reg[1] <= in_pos[3*CB-1:2*CB]; py_reg[1] <= in_pos[4*CB-1:3*CB];
                    px_reg[2] <= in_pos[5*CB-1:4*CB]; py_reg[2] <= in_pos[6*CB-1:5*CB];
                    w_reg <= in_w; h_reg <= in_h; flg_reg <= in_flags;
                    status_reg <= ST_OK;
                    sbv_reg <= 1'b0; sb_reg <= '0; sbt_reg <= 1'b0; st_reg <= '0;
                    held_reg <= 1'b0; pr_reg <= 1'b0; rel_reg <= 1'b0;
                    i_reg <= '0; k_reg <= '0;
                end
                OP_CHK_FULL:
                begin
                    if (stat.full)
                        status_reg <= stat.is_add ? ST_BOX_FULL : ST_BTN_FULL;
                    i_reg <= len_reg;
                end
                OP_SHIFT:
                begin
                    order_reg[BI'(i_reg)] <= order_reg[BI'(i_reg - 1'b1)];
                    i_reg <= i_reg - 1'b1;
                end
                OP_ADD:
                begin
                    cnt_reg[bidx] <= '0;
                    if (act_reg == ACT_ADD_FRONT)
                        order_reg[0] <= bidx;
                    else
                        order_reg[BI'(len_reg)] <= bidx;
                    len_reg <= len_reg + 1'b1;
                end
                OP_REM:
                begin
                    if (stat.rem_done)
                        len_reg <= k_reg;
                    else
                    begin
                        if (order_reg[BI'(i_reg)] != bidx)
                        begin
                            order_reg[BI'(k_reg)] <= order_reg[BI'(i_reg)];
                            k_reg <= k_reg + 1'b1;
                        end
                        i_reg <= i_reg + 1'b1;
                    end
                end
                OP_APPEND: cnt_reg[bidx] <= cnt_reg[bidx] + 1'b1;
                OP_HT_START:
                begin
                    i_reg <= '0;
                    tx_reg <= $signed(px_reg[cmd.phase]);
                    ty_reg <= $signed(py_reg[cmd.phase]);
                end
                OP_BOX_TST:
                begin
                    if (box_in)
                    begin
                        sbv_reg <= 1'b1;
                        sb_reg <= order_reg[BI'(i_reg)];
                        cur_reg <= order_reg[BI'(i_reg)];
                        n_reg <= cnt_reg[order_reg[BI'(i_reg)]];
                        j_reg <= '0;
                        dx_reg <= bx; dy_reg <= by;
                    end
                    else
                        i_reg <= i_reg + 1'b1;
                end
                OP_BTN_TST:
                begin
                    if (btn_in)
                    begin
                        sbt_reg <= 1'b1;
                        st_reg <= NI'(j_reg);
                    end
                    j_reg <= j_reg + 1'b1;
                end
                OP_HT_END:
                begin
                    if (cmd.phase == 2'd0)
                        held_reg <= flg_reg[0] && sbt_reg && tbv_reg && ttv_reg && sbv_reg
                                    && sb_reg == tb_reg && st_reg == tt_reg;
                    else if (cmd.phase == 2'd1)
                    begin
                        if (!sbt_reg)
                        begin
                            tbv_reg <= 1'b0; tb_reg <= '0; ttv_reg <= 1'b0; tt_reg <= '0;
                        end
                        else
                        begin
                            tbv_reg <= sbv_reg; tb_reg <= sb_reg;
                            ttv_reg <= 1'b1; tt_reg <= st_reg; pr_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        rel_reg <= sbv_reg && tbv_reg && sb_reg == tb_reg && sbt_reg
                                   && ttv_reg && st_reg == tt_reg;
                        tbv_reg <= 1'b0; tb_reg <= '0; ttv_reg <= 1'b0; tt_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        result = {rel_reg, pr_reg, held_reg,
                  sbt_reg ? 5'(st_reg) : 5'd0, sbt_reg,
                  sbv_reg ? 4'(sb_reg) : 4'd0, sbv_reg, status_reg};
    end
endmodule
`default_nettype wire

// ----- src/cbht_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cbht_ctrl
    import cbht_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_fire,
    input  wire logic  out_fire,
    input  wire stat_t stat,
    output cmd_t       cmd,
    output logic       in_ready,
    output logic       out_valid
);
    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_CHK, S_SHIFT, S_ADD, S_REM, S_APP,
        S_HT, S_BRD, S_BTST, S_NRD, S_NTST, S_HEND, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] ph_reg, ph_next;

    always_comb
    begin
        state_next = state_reg;
        ph_next = ph_reg;
        cmd.op = OP_NONE;
        cmd.phase = ph_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) begin cmd.op = OP_LATCH; state_next = S_DEC; end
            S_DEC:
            begin
                if (stat.is_add || stat.is_app) state_next = S_CHK;
                else if (stat.is_rem) state_next = S_REM;
                else if (stat.is_chk) begin ph_next = 2'd0; state_next = S_HT; end
                else state_next = S_OUT;
            end
            S_CHK:
            begin
                cmd.op = OP_CHK_FULL;
                if (stat.full) state_next = S_OUT;
                else if (stat.is_add) state_next = S_SHIFT;
                else state_next = S_APP;
            end
            S_SHIFT:
                if (stat.shift_done) state_next = S_ADD;
                else cmd.op = OP_SHIFT;
            S_ADD: begin cmd.op = OP_ADD; state_next = S_OUT; end
            S_APP: begin cmd.op = OP_APPEND; state_next = S_OUT; end
            S_REM: begin cmd.op = OP_REM; if (stat.rem_done) state_next = S_OUT; end
            S_HT:  begin cmd.op = OP_HT_START; state_next = S_BRD; end
            S_BRD:
                if (stat.box_end) state_next = S_HEND;
                else begin cmd.op = OP_BOX_RD; state_next = S_BTST; end
            S_BTST:
            begin
                cmd.op = OP_BOX_TST;
                state_next = stat.box_in ? S_NRD : S_BRD;
            end
            S_NRD:
                if (stat.btn_end) state_next = S_HEND;
                else begin cmd.op = OP_BTN_RD; state_next = S_NTST; end
            S_NTST:
            begin
                cmd.op = OP_BTN_TST;
                state_next = stat.btn_in ? S_HEND : S_NRD;
            end
            S_HEND:
            begin
                cmd.op = OP_HT_END;
                if (ph_reg == 2'd0 && stat.ph_down) begin ph_next = 2'd1; state_next = S_HT; end
                else if (ph_reg != 2'd2 && stat.ph_up) begin ph_next = 2'd2; state_next = S_HT; end
                else state_next = S_OUT;
            end
            S_OUT: if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ph_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg <= ph_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = state_reg == S_OUT;
endmodule
`default_nettype wire

// ----- src/click_box_hit_tracker.sv -----
// channel | dir | tdata fields (low bit up)                                   | tuser
// s_axis  | in  | box_id,pos_x,pos_y,rect_w,rect_h,down_x,down_y,up_x,up_y     | action,mouse_flags
// m_axis  | out | status,box_hit,hit_box,button_hit,hit_button,held,pressed,released | -
// One word at a time. A front add first shifts the order list (one shift a cycle); a
// remove walks the whole list. A check runs each of its up to 3 tests by walking the
// boxes and then the buttons of the hit box, through the registered rect read.
// Reset is asynchronous; order length and button counts clear at once.
// Output held until taken; no new word accepted until the cycle after it is taken.
`timescale 1ns / 1ps
`default_nettype none
module click_box_hit_tracker
    import cbht_pkg::*;
#(
    parameter int MAX_BOXES   = MAX_BOXES_DEF,
    parameter int MAX_BUTTONS = MAX_BUTTONS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // box_id, pos_x, pos_y, rect_w, rect_h, down_x, down_y, up_x, up_y, zero pad
    input  wire logic [((6*COORD_BITS+2*RW+ID_W+7)/8)*8-1:0] s_axis_tdata,
    // action, mouse_flags, zero pad
    input  wire logic [7:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status, box_hit, hit_box, button_hit, hit_button, held, pressed, released
    output logic [15:0]       m_axis_tdata
);
    localparam int CB = COORD_BITS;
    localparam int O  = ID_W + 2*CB;

    cmd_t  cmd;
    stat_t stat;
    logic [15:0] res;
    logic [6*CB-1:0] pos;

    assign pos = {s_axis_tdata[O+2*RW+4*CB-1:O+2*RW], s_axis_tdata[O-1:ID_W]};

    cbht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .stat(stat), .cmd(cmd),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    cbht_datapath #(.MAX_BOXES(MAX_BOXES), .MAX_BUTTONS(MAX_BUTTONS), .COORD_BITS(COORD_BITS))
    u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_action(s_axis_tuser[2:0]), .in_box(s_axis_tdata[ID_W-1:0]),
        .in_pos(pos),
        .in_w(s_axis_tdata[O+RW-1:O]), .in_h(s_axis_tdata[O+2*RW-1:O+RW]),
        .in_flags(s_axis_tuser[5:3]),
        .cmd(cmd), .stat(stat), .result(res)
    );

    assign m_axis_tdata = res;

    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[2] |-> m_axis_tdata[6:3] == 4'd0)
        else $error("hit_box without box_hit");
endmodule
`default_nettype wire

// ----- tb/tb_click_box_hit_tracker.sv -----
`timescale 1ns / 1ps
module tb_click_box_hit_tracker;
    import cbht_pkg::*;

    localparam int NBOX = MAX_BOXES_DEF;
    localparam int NBTN = MAX_BUTTONS_DEF;
    localparam int DW   = ((6*COORD_BITS_DEF+2*RW+ID_W+7)/8)*8;
    localparam int N_RANDOM = 1680;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [2:0]         act;
        logic [3:0]         box;
        logic signed [15:0] px, py;
        logic [14:0]        w, h;
        logic signed [15:0] dx, dy, ux, uy;
        logic [2:0]         flags;
    } word_t;

    typedef struct {
        word_t      wd;
        int         rep;
        bit         has_exp;
        logic [15:0] exp_res;
    } row_t;

    typedef struct {
        longint x, y, w, h;
    } rect_t;

    logic            clk = 0;
    logic            rst_n = 0;
    logic            s_axis_tvalid = 0;
    logic            s_axis_tready;
    logic [DW-1:0]   s_axis_tdata = '0;
    logic [7:0]      s_axis_tuser = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 0;
    logic [15:0]     m_axis_tdata;

    click_box_hit_tracker i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // hit tracker shadow state
    rect_t       box_rect [NBOX];
    int          btn_cnt [NBOX];
    rect_t       btn_rect [NBOX][NBTN];
    int          order_q [NBOX];
    int          order_len;
    bit          trk_box_v, trk_btn_v;
    int          trk_box, trk_btn;
    bit          sel_box_v, sel_btn_v;
    int          sel_box, sel_btn;

    logic [15:0] result_q[$];
    int          errors = 0;
    int          sent = 0;
    int          results_seen = 0;
    int          presses = 0, releases = 0, fulls = 0;
    int          sidle = 0, ridle = 0;
    bit          hold_rx = 0;
    row_t        rows[$];
    word_t       wd_cur;

    function automatic bit in_rect(longint ox, longint oy, rect_t r);
        return ox >= 0 && ox < r.w && oy >= 0 && oy < r.h;
    endfunction

    task automatic hit_walk(longint px, longint py);
        int b;
        longint ox, oy;
        for (int i = 0; i < order_len; i++)
        begin
            b = order_q[i];
            ox = px - box_rect[b].x;
            oy = py - box_rect[b].y;
            if (in_rect(ox, oy, box_rect[b]))
            begin
                sel_box_v = 1;
                sel_box = b;
                for (int j = 0; j < btn_cnt[b]; j++)
                begin
                    if (in_rect(ox - btn_rect[b][j].x, oy - btn_rect[b][j].y,
                                btn_rect[b][j]))
                    begin
                        sel_btn_v = 1;
                        sel_btn = j;
                        break;
                    end
                end
                return;
            end
        end
    endtask

    function automatic logic [15:0] pack_res(logic [1:0] st, bit bh, int hb, bit nh, int hn,
                                             bit held, bit prs, bit rel);
        return {rel, prs, held, 5'(hn), nh, 4'(hb), bh, st};
    endfunction

    task automatic predict_word(word_t wd, output logic [15:0] res);
        logic [1:0] st;
        bit held, prs, rel;
        int k;
        rect_t r;
        st = ST_OK;
        held = 0; prs = 0; rel = 0;
        sel_box_v = 0; sel_box = 0; sel_btn_v = 0; sel_btn = 0;
        r.x = longint'(wd.px); r.y = longint'(wd.py);
        r.w = longint'(wd.w);  r.h = longint'(wd.h);
        case (wd.act)
            ACT_ADD_FRONT, ACT_ADD_BACK:
            begin
                if (order_len >= NBOX)
                    st = ST_BOX_FULL;
                else
                begin
                    box_rect[wd.box] = r;
                    btn_cnt[wd.box] = 0;
                    if (wd.act == ACT_ADD_FRONT)
                    begin
                        for (int i = order_len; i > 0; i--)
                            order_q[i] = order_q[i-1];
                        order_q[0] = wd.box;
                    end
                    else
                        order_q[order_len] = wd.box;
                    order_len++;
                end
            end
            ACT_REMOVE:
            begin
                k = 0;
                for (int i = 0; i < order_len; i++)
                    if (order_q[i] != wd.box)
                        order_q[k++] = order_q[i];
                order_len = k;
            end
            ACT_APPEND:
            begin
                if (btn_cnt[wd.box] >= NBTN)
                    st = ST_BTN_FULL;
                else
                begin
                    btn_rect[wd.box][btn_cnt[wd.box]] = r;
                    btn_cnt[wd.box]++;
                end
            end
            ACT_CHECK:
            begin
                hit_walk(wd.px, wd.py);
                if (wd.flags[0] && sel_btn_v && trk_box_v && trk_btn_v && sel_box_v &&
                    sel_box == trk_box && sel_btn == trk_btn)
                    held = 1;
                if (wd.flags[1])
                begin
                    hit_walk(wd.dx, wd.dy);
                    if (!sel_btn_v)
                    begin
                        trk_box_v = 0; trk_box = 0; trk_btn_v = 0; trk_btn = 0;
                    end
                    else
                    begin
                        trk_box_v = sel_box_v; trk_box = sel_box;
                        trk_btn_v = 1; trk_btn = sel_btn;
                        prs = 1;
                    end
                end
                if (wd.flags[2])
                begin
                    hit_walk(wd.ux, wd.uy);
                    if (sel_box_v && trk_box_v && sel_box == trk_box &&
                        sel_btn_v && trk_btn_v && sel_btn == trk_btn)
                        rel = 1;
                    trk_box_v = 0; trk_box = 0; trk_btn_v = 0; trk_btn = 0;
                end
            end
            default: ;
        endcase
        res = pack_res(st, sel_box_v, sel_box_v ? sel_box : 0, sel_btn_v,
                       sel_btn_v ? sel_btn : 0, held, prs, rel);
    endtask

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    // acceptance: predict on input, compare on output
    always @(posedge clk)
    begin
        logic [15:0] res, want;
        if (s_axis_tvalid && s_axis_tready)
        begin
            predict_word(wd_cur, res);
            result_q.insert(result_q.size(), res);
        end
        if (m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (result_q.size() == 0)
                report("unexpected word", m_axis_tdata, 0);
            else
            begin
                want = result_q[0];
                result_q.delete(0);
                if (m_axis_tdata[14]) presses++;
                if (m_axis_tdata[15]) releases++;
                if (m_axis_tdata[1:0] != ST_OK) fulls++;
                if (m_axis_tdata[1:0] != want[1:0]) report("status", m_axis_tdata[1:0], want[1:0]);
                if (m_axis_tdata[2] != want[2]) report("box_hit", m_axis_tdata[2], want[2]);
                if (m_axis_tdata[6:3] != want[6:3]) report("hit_box", m_axis_tdata[6:3], want[6:3]);
                if (m_axis_tdata[7] != want[7]) report("button_hit", m_axis_tdata[7], want[7]);
                if (m_axis_tdata[12:8] != want[12:8])
                    report("hit_button", m_axis_tdata[12:8], want[12:8]);
                if (m_axis_tdata[13] != want[13]) report("held", m_axis_tdata[13], want[13]);
                if (m_axis_tdata[14] != want[14]) report("pressed", m_axis_tdata[14], want[14]);
                if (m_axis_tdata[15] != want[15]) report("released", m_axis_tdata[15], want[15]);
            end
        end
    end

    // typed-in expectations for directed rows, checked beside the shadow model
    logic [15:0] fixed_res_q[$];
    bit          fixed_tag_q[$];
    bit          fixed_pending = 0;
    logic [15:0] fixed_cur = '0;
    always @(posedge clk)
    begin
        logic [15:0] fexp;
        bit ftag;
        if (m_axis_tvalid && m_axis_tready && fixed_tag_q.size() != 0)
        begin
            ftag = fixed_tag_q[0];
            fixed_tag_q.delete(0);
            if (ftag && fixed_res_q.size() != 0)
            begin
                fexp = fixed_res_q[0];
                fixed_res_q.delete(0);
                if (m_axis_tdata != fexp)
                    report("directed word", m_axis_tdata, fexp);
            end
        end
        if (s_axis_tvalid && s_axis_tready)
        begin
            fixed_tag_q.insert(fixed_tag_q.size(), fixed_pending);
            if (fixed_pending)
                fixed_res_q.insert(fixed_res_q.size(), fixed_cur);
        end
    end

    always @(posedge clk)
    begin
        if (hold_rx)
            m_axis_tready <= 0;
        else
            m_axis_tready <= ($urandom_range(99) >= ridle);
    end

    longint cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_word(word_t wd, bit fx, logic [15:0] fres);
        while ($urandom_range(99) < sidle)
        begin
            s_axis_tvalid <= 0;
            @(posedge clk);
        end
        wd_cur <= wd;
        fixed_pending <= fx;
        fixed_cur <= fres;
        s_axis_tvalid <= 1;
        s_axis_tuser <= {2'b00, wd.flags, wd.act};
        s_axis_tdata <= DW'({wd.uy, wd.ux, wd.dy, wd.dx, wd.h, wd.w, wd.py, wd.px, wd.box});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent++;
    endtask

    function automatic word_t mk(logic [2:0] act, logic [3:0] box, int px, int py, int w, int h,
                                 int dx, int dy, int ux, int uy, logic [2:0] flags);
        word_t wd;
        wd.act = act; wd.box = box; wd.px = 16'(px); wd.py = 16'(py);
        wd.w = 15'(w); wd.h = 15'(h);
        wd.dx = 16'(dx); wd.dy = 16'(dy); wd.ux = 16'(ux); wd.uy = 16'(uy); wd.flags = flags;
        return wd;
    endfunction

    task automatic add_row(word_t wd, int rep = 1, bit has_exp = 0, logic [15:0] er = '0);
        row_t r;
        r.wd = wd; r.rep = rep; r.has_exp = has_exp; r.exp_res = er;
        rows.insert(rows.size(), r);
    endtask

    function automatic int coord();
        if ($urandom_range(9) == 0)
            return $signed(16'($urandom));
        return $urandom_range(255) - 64;
    endfunction

    function automatic word_t rand_word();
        word_t wd;
        int pick;
        pick = $urandom_range(99);
        wd.box = 4'($urandom_range(15));
        wd.flags = 3'($urandom_range(7));
        wd.px = 16'(coord()); wd.py = 16'(coord());
        wd.dx = 16'(coord()); wd.dy = 16'(coord());
        wd.ux = 16'(coord()); wd.uy = 16'(coord());
        wd.w = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(128));
        wd.h = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(128));
        if (pick < 25)
            wd.act = pick[0] ? ACT_ADD_BACK : ACT_ADD_FRONT;
        else if (pick < 35)
            wd.act = ACT_REMOVE;
        else if (pick < 60)
        begin
            wd.act = ACT_APPEND;
            wd.px = 16'($urandom_range(64)); wd.py = 16'($urandom_range(64));
            wd.w = 15'($urandom_range(1, 40)); wd.h = 15'($urandom_range(1, 40));
        end
        else if (pick < 96)
        begin
            wd.act = ACT_CHECK;
            if ($urandom_range(1))
            begin
                wd.ux = wd.dx; wd.uy = wd.dy;
            end
        end
        else
            wd.act = 3'($urandom_range(5, 7));
        return wd;
    endfunction

    initial
    begin
        int idle_pct [4][2];
        for (int b = 0; b < NBOX; b++)
            btn_cnt[b] = 0;
        order_len = 0;
        trk_box_v = 0; trk_box = 0; trk_btn_v = 0; trk_btn = 0;

        add_row(mk(ACT_CHECK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd7), 1, 1, '0);
        add_row(mk(ACT_REMOVE, 3, 0, 0, 0, 0, 0, 0, 0, 0, 3'd0), 1, 1, '0);
        add_row(mk(3'd5, 4'hF, -1, -1, 32767, 32767, -1, -1, -1, -1, 3'd7), 1, 1, '0);
        add_row(mk(3'd7, 4'hF, -1, -1, 32767, 32767, -1, -1, -1, -1, 3'd7), 1, 1, '0);
        add_row(mk(ACT_ADD_FRONT, 2, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0), 1, 1, '0);
        add_row(mk(ACT_APPEND, 2, 0, 0, 10, 10, 0, 0, 0, 0, 0), 1, 1, '0);
        add_row(mk(ACT_APPEND, 2, 20, 20, 5, 5, 0, 0, 0, 0, 0));
        add_row(mk(ACT_CHECK, 0, -32768, -32768, 0, 0, 0, 0, 0, 0, 3'd0));
        add_row(mk(ACT_CHECK, 0, 0, 0, 0, 0, -32763, -32763, 0, 0, 3'd2));
        add_row(mk(ACT_CHECK, 0, -32764, -32764, 0, 0, 0, 0, 0, 0, 3'd1));
        add_row(mk(ACT_CHECK, 0, -32764, -32764, 0, 0, 0, 0, -32766, -32766, 3'd5));
        add_row(mk(ACT_CHECK, 0, 0, 0, 0, 0, -30000, -30000, 32767, 32767, 3'd6));
        add_row(mk(ACT_CHECK, 0, 0, 0, 0, 0, -32747, -32747, -32746, -32746, 3'd7));
        add_row(mk(ACT_ADD_BACK, 5, 32767, 32767, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(ACT_CHECK, 0, 32767, 32767, 0, 0, 32767, 32767, 32767, 32767, 3'd7));
        add_row(mk(ACT_ADD_FRONT, 2, 0, 0, 100, 100, 0, 0, 0, 0, 0));
        add_row(mk(ACT_CHECK, 0, 5, 5, 0, 0, 5, 5, 5, 5, 3'd7));
        add_row(mk(ACT_ADD_FRONT, 7, 50, 50, 8, 8, 0, 0, 0, 0, 0), 13);
        add_row(mk(ACT_ADD_BACK, 9, 0, 0, 1, 1, 0, 0, 0, 0, 0), 1, 1, 16'(ST_BOX_FULL));
        add_row(mk(ACT_REMOVE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk(ACT_APPEND, 4, 1, 1, 1, 1, 0, 0, 0, 0, 0), 32);
        add_row(mk(ACT_APPEND, 4, 0, 0, 1, 1, 0, 0, 0, 0, 0), 1, 1, 16'(ST_BTN_FULL));
        add_row(mk(ACT_ADD_BACK, 4, 0, 0, 32767, 32767, 0, 0, 0, 0, 0));
        add_row(mk(ACT_CHECK, 0, 60, 60, 0, 0, 1, 1, 1, 1, 3'd7));

        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        foreach (rows[i])
            for (int k = 0; k < rows[i].rep; k++)
                send_word(rows[i].wd, rows[i].has_exp, rows[i].exp_res);

        idle_pct = '{'{0, 0}, '{78, 0}, '{0, 78}, '{38, 38}};
        for (int ph = 0; ph < 4; ph++)
        begin
            sidle = idle_pct[ph][0];
            ridle = idle_pct[ph][1];
            if (ph == 1)
                fork
                    begin
                        hold_rx = 1;
                        repeat (600) @(posedge clk);
                        hold_rx = 0;
                    end
                join_none
            repeat (N_RANDOM / 4)
                send_word(rand_word(), 0, '0);
        end
        s_axis_tvalid <= 0;
        sidle = 0;

        while (result_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (result_q.size() != 0 || fixed_res_q.size() != 0)
            report("words left over", result_q.size(), 0);

        $display("sent %0d words, checked %0d results across four idle phases",
                 sent, results_seen);
        $display("presses %0d, releases %0d, full-table statuses %0d",
                 presses, releases, fulls);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
